/* hdl/delta_list_timer_queue_core_macros.svh */
// Assertion macros shared by the timer queue modules.
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef DELTA_LIST_TIMER_QUEUE_CORE_MACROS_SVH
`define DELTA_LIST_TIMER_QUEUE_CORE_MACROS_SVH

// Same-cycle implication.
`define DLTQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define DLTQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/dltq_pkg.sv */
// Shared types and codes for the delta-list timer queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package dltq_pkg;

	localparam int DEF_SLOTS = 16;
	localparam int DW        = 16;

	// Opcodes of an input word.
	localparam logic [2:0] OP_SET      = 3'd0;
	localparam logic [2:0] OP_CANCEL   = 3'd1;
	localparam logic [2:0] OP_TICK     = 3'd2;
	localparam logic [2:0] OP_COMPLETE = 3'd3;
	localparam logic [2:0] OP_STATUS   = 3'd4;

	// Result kinds.
	localparam logic [3:0] K_SET_OK      = 4'd0;
	localparam logic [3:0] K_SET_FULL    = 4'd1;
	localparam logic [3:0] K_CANCEL_OK   = 4'd2;
	localparam logic [3:0] K_CANCEL_FAIL = 4'd3;
	localparam logic [3:0] K_HIGH_FIRED  = 4'd4;
	localparam logic [3:0] K_LOW_POSTED  = 4'd5;
	localparam logic [3:0] K_LOW_HANDLER = 4'd6;
	localparam logic [3:0] K_DONE        = 4'd7;
	localparam logic [3:0] K_STATUS      = 4'd8;

	// Slot occupancy codes.
	localparam logic [1:0] SK_FREE = 2'd0;
	localparam logic [1:0] SK_LOW  = 2'd1;
	localparam logic [1:0] SK_HIGH = 2'd2;

	// Datapath micro-operations.
	typedef enum logic [3:0] {
		UOP_NONE, UOP_LOAD, UOP_SRCH, UOP_CLAIM, UOP_WSTART, UOP_WALK,
		UOP_L1, UOP_L2, UOP_U0, UOP_U1, UOP_U2, UOP_TDEC, UOP_THEAD
	} uop_t;

	typedef enum logic [1:0] {SLOT_CUR, SLOT_ID, SLOT_ZERO} slot_sel_t;

	typedef struct packed {
		uop_t       uop;
		logic       emit;
		logic [3:0] kind;
		logic       last;
		logic       no_id;
		logic       running;
		slot_sel_t  slot_sel;
		logic       free;
	} dltq_cmd_t;

	typedef struct packed {
		logic [1:0] cur_kind;
		logic       id_ok;
		logic       head_valid;
		logic       rd_zero;
		logic       srch_free;
		logic       srch_last;
		logic       walk_gt;
		logic       rn_none;
		logic       out_free;
		logic       hi;
		logic       delay_zero;
	} dltq_stat_t;

endpackage

/* hdl/dltq_dp.sv */
// Datapath of the timer queue: slot tables, list pointers, walk registers
// and the output register. Depends on dltq_pkg and the assertion macros.
`include "delta_list_timer_queue_core_macros.svh"

module dltq_dp import dltq_pkg::*; #(
	parameter int SLOTS = DEF_SLOTS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_hi,
	input  logic [DW-1:0] in_delay,
	input  logic [3:0]    in_id,
	input  dltq_cmd_t     cmd,
	output dltq_stat_t    st,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [3:0]    out_kind,
	output logic [3:0]    out_slot,
	output logic          out_no_id,
	output logic          out_running,
	output logic          out_last
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PW = $clog2(SLOTS + 1);
	localparam logic [PW-1:0] NONE     = PW'(SLOTS);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	logic [1:0]    kind_q  [SLOTS];
	logic [DW-1:0] delta_q [SLOTS];
	logic [PW-1:0] prev_q  [SLOTS];
	logic [PW-1:0] next_q  [SLOTS];
	logic [PW-1:0] head_q;
	logic [IW-1:0] search_q;

	logic [IW-1:0] idx_q, cnt_q, cur_q;
	logic [PW-1:0] walk_q, prv_q;
	logic [DW-1:0] d_q, delay_q;
	logic          hi_q;
	logic [3:0]    id_q;
	logic          out_valid_q;

	logic [IW-1:0] ra;
	logic [1:0]    rk;
	logic [DW-1:0] rd;
	logic [PW-1:0] rp, rn;
	logic [PW-1:0] cur_p;
	logic [8:0]    cur_ext;

	// Single read port, address chosen by the micro-operation.
	always_comb begin
		unique case (cmd.uop)
			UOP_SRCH:              ra = idx_q;
			UOP_WALK, UOP_U2:      ra = walk_q[IW-1:0];
			UOP_TDEC, UOP_THEAD:   ra = head_q[IW-1:0];
			default:               ra = cur_q;
		endcase
	end

	assign rk      = kind_q[ra];
	assign rd      = delta_q[ra];
	assign rp      = prev_q[ra];
	assign rn      = next_q[ra];
	assign cur_p   = PW'(cur_q);
	assign cur_ext = 9'(cur_q);

	// Status flags for the controller.
	always_comb begin
		st.cur_kind   = rk;
		st.id_ok      = ({5'd0, id_q} < 9'(SLOTS));
		st.head_valid = (head_q != NONE);
		st.rd_zero    = (rd == '0);
		st.srch_free  = (rk == SK_FREE);
		st.srch_last  = (cnt_q == LAST_IDX);
		st.walk_gt    = (rd > d_q);
		st.rn_none    = (rn == NONE);
		st.out_free   = !out_valid_q || out_ready;
		st.hi         = hi_q;
		st.delay_zero = (delay_q == '0);
	end

	// Slot tables and list head; one write address per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				kind_q[i]  <= SK_FREE;
				delta_q[i] <= '0;
				prev_q[i]  <= NONE;
				next_q[i]  <= NONE;
			end
			head_q      <= NONE;
			search_q    <= LAST_IDX;
			out_valid_q <= 1'b0;
		end else begin
			unique case (cmd.uop)
				UOP_CLAIM: begin
					search_q <= idx_q;
					if (delay_q == '0 && hi_q)
						kind_q[idx_q] <= SK_FREE;
					else
						kind_q[idx_q] <= hi_q ? SK_HIGH : SK_LOW;
					delta_q[idx_q] <= delay_q;
					prev_q[idx_q]  <= NONE;
					next_q[idx_q]  <= NONE;
				end
				UOP_WSTART: begin
					if (head_q == NONE)
						head_q <= cur_p;
				end
				UOP_WALK: begin
					if (rd > d_q) begin
						delta_q[ra] <= rd - d_q;
						prev_q[ra]  <= cur_p;
					end
				end
				UOP_L1: begin
					delta_q[cur_q] <= d_q;
					prev_q[cur_q]  <= prv_q;
					next_q[cur_q]  <= walk_q;
					if (prv_q == NONE)
						head_q <= cur_p;
				end
				UOP_L2: begin
					if (prv_q != NONE)
						next_q[prv_q[IW-1:0]] <= cur_p;
				end
				UOP_U0: begin
					if (head_q == cur_p)
						head_q <= rn;
					prev_q[cur_q] <= NONE;
					next_q[cur_q] <= NONE;
					if (cmd.free) begin
						kind_q[cur_q]  <= SK_FREE;
						delta_q[cur_q] <= '0;
					end
				end
				UOP_U1: begin
					if (prv_q != NONE)
						next_q[prv_q[IW-1:0]] <= walk_q;
				end
				UOP_U2: begin
					if (walk_q != NONE) begin
						delta_q[ra] <= rd + d_q;
						prev_q[ra]  <= prv_q;
					end
				end
				UOP_TDEC: begin
					delta_q[ra] <= rd - 1'b1;
				end
				default: ;
			endcase
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Working registers of the current word and the result payload.
	always_ff @(posedge clk) begin
		unique case (cmd.uop)
			UOP_LOAD: begin
				hi_q    <= in_hi;
				delay_q <= in_delay;
				id_q    <= in_id;
				cur_q   <= IW'({5'd0, in_id});
				idx_q   <= (search_q == LAST_IDX) ? '0 : search_q + 1'b1;
				cnt_q   <= '0;
			end
			UOP_SRCH: begin
				if (rk != SK_FREE)
					idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
				cnt_q <= cnt_q + 1'b1;
			end
			UOP_CLAIM: begin
				cur_q <= idx_q;
			end
			UOP_WSTART: begin
				walk_q <= head_q;
				prv_q  <= NONE;
				d_q    <= delay_q;
			end
			UOP_WALK: begin
				if (!(rd > d_q)) begin
					d_q    <= d_q - rd;
					prv_q  <= PW'(ra);
					walk_q <= rn;
				end
			end
			UOP_U0: begin
				prv_q  <= rp;
				walk_q <= rn;
				d_q    <= rd;
			end
			UOP_THEAD: begin
				cur_q <= head_q[IW-1:0];
			end
			default: ;
		endcase
		if (cmd.emit) begin
			out_kind    <= cmd.kind;
			out_no_id   <= cmd.no_id;
			out_running <= cmd.running;
			out_last    <= cmd.last;
			unique case (cmd.slot_sel)
				SLOT_CUR: out_slot <= cur_ext[3:0];
				SLOT_ID:  out_slot <= id_q;
				default:  out_slot <= 4'd0;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	// An armed head slot is never free.
	`DLTQ_ASSERT_IMP(a_head_armed, head_q != NONE, kind_q[head_q[IW-1:0]] != SK_FREE, "free slot at list head")
	// Ticks only decrement an existing head.
	`DLTQ_ASSERT_IMP(a_tdec_head, cmd.uop == UOP_TDEC, head_q != NONE, "tick decrement without head")
	// A loaded result is presented in the next cycle.
	`DLTQ_ASSERT_NXT(a_emit_shown, cmd.emit, out_valid_q, "emitted result not presented")

endmodule

/* hdl/dltq_ctrl.sv */
// Controller of the timer queue: sequences search, insertion, unlink and
// tick firing as datapath micro-operations. Depends on dltq_pkg and macros.
`include "delta_list_timer_queue_core_macros.svh"

module dltq_ctrl import dltq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] in_op,
	input  dltq_stat_t st,
	output dltq_cmd_t  cmd
);

	typedef enum logic [18:0] {
		S_IDLE   = 19'h00001,
		S_SRCH   = 19'h00002,
		S_FULL   = 19'h00004,
		S_CLAIM  = 19'h00008,
		S_FIRE0  = 19'h00010,
		S_SETOK  = 19'h00020,
		S_WSTART = 19'h00040,
		S_WALK   = 19'h00080,
		S_L1     = 19'h00100,
		S_L2     = 19'h00200,
		S_CHK    = 19'h00400,
		S_U0     = 19'h00800,
		S_U1     = 19'h01000,
		S_U2     = 19'h02000,
		S_RES    = 19'h04000,
		S_TDEC   = 19'h08000,
		S_THEAD  = 19'h10000,
		S_TFIRE  = 19'h20000,
		S_TDONE  = 19'h40000
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] op_q;
	logic       hit_q, hit_d;

	// Next state and micro-operation.
	always_comb begin
		state_d      = state_q;
		hit_d        = hit_q;
		in_ready     = 1'b0;
		cmd.uop      = UOP_NONE;
		cmd.emit     = 1'b0;
		cmd.kind     = K_SET_OK;
		cmd.last     = 1'b0;
		cmd.no_id    = 1'b0;
		cmd.running  = 1'b0;
		cmd.slot_sel = SLOT_CUR;
		cmd.free     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.uop = UOP_LOAD;
					unique case (in_op)
						OP_SET:                             state_d = S_SRCH;
						OP_CANCEL, OP_COMPLETE, OP_STATUS:  state_d = S_CHK;
						OP_TICK:                            state_d = S_TDEC;
						default:                            state_d = S_IDLE;
					endcase
				end
			end
			S_SRCH: begin
				cmd.uop = UOP_SRCH;
				if (st.srch_free)
					state_d = S_CLAIM;
				else if (st.srch_last)
					state_d = S_FULL;
			end
			S_FULL: begin
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.kind     = K_SET_FULL;
					cmd.slot_sel = SLOT_ZERO;
					cmd.last     = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_CLAIM: begin
				cmd.uop = UOP_CLAIM;
				state_d = st.delay_zero ? S_FIRE0 : S_WSTART;
			end
			S_FIRE0: begin
				if (st.out_free) begin
					cmd.emit  = 1'b1;
					cmd.kind  = st.hi ? K_HIGH_FIRED : K_LOW_POSTED;
					cmd.no_id = st.hi;
					state_d   = S_SETOK;
				end
			end
			S_SETOK: begin
				if (st.out_free) begin
					cmd.emit  = 1'b1;
					cmd.kind  = K_SET_OK;
					cmd.no_id = st.hi && st.delay_zero;
					cmd.last  = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_WSTART: begin
				cmd.uop = UOP_WSTART;
				state_d = st.head_valid ? S_WALK : S_SETOK;
			end
			S_WALK: begin
				cmd.uop = UOP_WALK;
				if (st.walk_gt || st.rn_none)
					state_d = S_L1;
			end
			S_L1: begin
				cmd.uop = UOP_L1;
				state_d = S_L2;
			end
			S_L2: begin
				cmd.uop = UOP_L2;
				state_d = S_SETOK;
			end
			S_CHK: begin
				unique case (op_q)
					OP_COMPLETE: hit_d = st.id_ok && (st.cur_kind == SK_LOW);
					default:     hit_d = st.id_ok && (st.cur_kind != SK_FREE);
				endcase
				state_d = (hit_d && op_q != OP_STATUS) ? S_U0 : S_RES;
			end
			S_U0: begin
				cmd.uop  = UOP_U0;
				cmd.free = (op_q != OP_TICK) || (st.cur_kind == SK_HIGH);
				state_d  = S_U1;
			end
			S_U1: begin
				cmd.uop = UOP_U1;
				state_d = S_U2;
			end
			S_U2: begin
				cmd.uop = UOP_U2;
				state_d = (op_q == OP_TICK) ? S_THEAD : S_RES;
			end
			S_RES: begin
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.slot_sel = SLOT_ID;
					cmd.last     = 1'b1;
					unique case (op_q)
						OP_CANCEL:   cmd.kind = hit_q ? K_CANCEL_OK : K_CANCEL_FAIL;
						OP_COMPLETE: cmd.kind = hit_q ? K_LOW_HANDLER : K_DONE;
						default: begin
							cmd.kind    = K_STATUS;
							cmd.running = hit_q;
						end
					endcase
					state_d = S_IDLE;
				end
			end
			S_TDEC: begin
				if (st.head_valid) begin
					cmd.uop = UOP_TDEC;
					state_d = S_THEAD;
				end else begin
					state_d = S_TDONE;
				end
			end
			S_THEAD: begin
				cmd.uop = UOP_THEAD;
				state_d = (st.head_valid && st.rd_zero) ? S_TFIRE : S_TDONE;
			end
			S_TFIRE: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = (st.cur_kind == SK_HIGH) ? K_HIGH_FIRED : K_LOW_POSTED;
					state_d  = S_U0;
				end
			end
			S_TDONE: begin
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.kind     = K_DONE;
					cmd.slot_sel = SLOT_ZERO;
					cmd.last     = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State, latched opcode and the hit flag of a lookup.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_SET;
			hit_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			hit_q   <= hit_d;
			if (in_valid && in_ready)
				op_q <= in_op;
		end
	end

	// A result is loaded only when the output register can take it.
	`DLTQ_ASSERT_IMP(a_emit_room, cmd.emit, st.out_free, "result loaded over a waiting word")
	// One word at a time: after a word that starts work the input side closes.
	`DLTQ_ASSERT_NXT(a_one_word, in_valid && in_ready && state_d != S_IDLE, !in_ready, "second word accepted")

endmodule

/* hdl/delta_list_timer_queue_core.sv */
// Pool of one-shot timers kept in a delta-sorted linked list.
//
// Input channel s_*: one word per request (set, cancel, tick, complete
// low timer, status). Output channel m_*: one or more result words per
// request; the final one carries m_tlast. Opcodes 5 to 7 give no result.
//
// One request is worked at a time. A set runs the round-robin free
// search over up to SLOTS slots, claims the free slot, walks up to
// SLOTS list entries, then links the timer and reports. A tick fires
// the expired timers at the list head in turn. The search and the list
// walk each read the slot tables through one port, one entry a cycle.
//
// Reset clears all slots to free, empties the list and restarts the free
// search at slot 0. When the receiver stalls, one result waits in the
// output register and the sequencer holds until it is taken.
// Depends on dltq_pkg, dltq_ctrl and dltq_dp.

module delta_list_timer_queue_core import dltq_pkg::*; #(
	parameter int SLOTS = DEF_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // high_priority, delay_ticks[15:0], timer_id[3:0], zero pad
	input  logic [2:0]  s_tuser,   // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // slot[3:0], no_id, running, zero pad
	output logic [3:0]  m_tuser,   // kind
	output logic        m_tlast    // last
);

	dltq_cmd_t  cmd;
	dltq_stat_t st;
	logic [3:0] slot;
	logic       no_id, running;

	dltq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (s_tuser),
		.st       (st),
		.cmd      (cmd)
	);

	dltq_dp #(.SLOTS(SLOTS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_hi       (s_tdata[0]),
		.in_delay    (s_tdata[16:1]),
		.in_id       (s_tdata[20:17]),
		.cmd         (cmd),
		.st          (st),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_kind    (m_tuser),
		.out_slot    (slot),
		.out_no_id   (no_id),
		.out_running (running),
		.out_last    (m_tlast)
	);

	// Pack the result word.
	assign m_tdata = {2'b00, running, no_id, slot};

endmodule

/* tb/tb_delta_list_timer_queue_core.sv */
// Self-checking testbench for delta_list_timer_queue_core: request words drive the
// timer pool, a behavioral predictor of the delta list computes result words.
// Depends on dltq_pkg and the core RTL.
module tb_delta_list_timer_queue_core import dltq_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOT = 16;
	localparam int NIL = NSLOT;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [3:0] kind;
		logic [3:0] slot;
		logic       no_id;
		logic       running;
		logic       last;
	} result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;

	delta_list_timer_queue_core dut (.*);

	// Predictor state: a copy of the slot tables and the delta list.
	logic [1:0]  pool_kind [NSLOT];
	logic [15:0] pool_delta [NSLOT];
	int          pool_prev [NSLOT];
	int          pool_next [NSLOT];
	int          pool_head;
	int          alloc_ptr;
	result_t     expected_results [$];

	int  mismatches = 0;
	int  idle_cycles = 0;
	bit  quiet_phase = 0;
	bit  hold_off = 0;
	bit  timed_out = 0;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	task automatic push_result(logic [3:0] k, int s, logic nid, logic run);
		result_t r;
		r.kind = k;
		r.slot = s[3:0];
		r.no_id = nid;
		r.running = run;
		r.last = 0;
		expected_results.push_back(r);
	endtask

	function automatic void release_slot(int i);
		pool_kind[i] = SK_FREE;
		pool_delta[i] = '0;
		pool_prev[i] = NIL;
		pool_next[i] = NIL;
	endfunction

	function automatic void unlink_entry(int i);
		int p, n;
		p = pool_prev[i];
		n = pool_next[i];
		if (pool_head == i) pool_head = n;
		if (p < NSLOT) pool_next[p] = n;
		if (n < NSLOT) begin
			pool_prev[n] = p;
			pool_delta[n] = pool_delta[n] + pool_delta[i];
		end
		pool_prev[i] = NIL;
		pool_next[i] = NIL;
	endfunction

	// Insert after every entry whose cumulative expiry is not later.
	function automatic void link_entry(int i);
		int cur, prv;
		logic [16:0] d;
		prv = NIL;
		d = pool_delta[i];
		if (pool_head >= NSLOT) begin
			pool_head = i;
			return;
		end
		cur = pool_head;
		while (cur < NSLOT && pool_delta[cur] <= d) begin
			d = d - pool_delta[cur];
			prv = cur;
			cur = pool_next[cur];
		end
		pool_delta[i] = d[15:0];
		if (cur < NSLOT) pool_delta[cur] = pool_delta[cur] - d[15:0];
		pool_prev[i] = prv;
		pool_next[i] = cur;
		if (prv < NSLOT) pool_next[prv] = i; else pool_head = i;
		if (cur < NSLOT) pool_prev[cur] = i;
	endfunction

	task automatic fire_timer(int i, logic nid);
		if (pool_kind[i] == SK_HIGH) begin
			push_result(K_HIGH_FIRED, i, nid, 0);
			unlink_entry(i);
			release_slot(i);
		end else if (pool_kind[i] == SK_LOW) begin
			unlink_entry(i);
			push_result(K_LOW_POSTED, i, 0, 0);
		end
	endtask

	task automatic predict_request(logic [2:0] op, logic hi, logic [15:0] dly, logic [3:0] id);
		int n_prior, idx;
		bit got;
		n_prior = expected_results.size();
		got = 0;
		idx = alloc_ptr;
		case (op)
			OP_SET: begin
				for (int k = 0; k < NSLOT && !got; k++) begin
					idx = (idx + 1) % NSLOT;
					if (pool_kind[idx] == SK_FREE) got = 1;
				end
				if (!got) begin
					push_result(K_SET_FULL, 0, 0, 0);
				end else begin
					alloc_ptr = idx;
					pool_kind[idx] = hi ? SK_HIGH : SK_LOW;
					pool_delta[idx] = dly;
					pool_prev[idx] = NIL;
					pool_next[idx] = NIL;
					if (dly == 0) begin
						fire_timer(idx, hi);
						push_result(K_SET_OK, idx, hi, 0);
					end else begin
						link_entry(idx);
						push_result(K_SET_OK, idx, 0, 0);
					end
				end
			end
			OP_CANCEL: begin
				if (pool_kind[id] != SK_FREE) begin
					unlink_entry(id);
					release_slot(id);
					push_result(K_CANCEL_OK, id, 0, 0);
				end else begin
					push_result(K_CANCEL_FAIL, id, 0, 0);
				end
			end
			OP_TICK: begin
				if (pool_head < NSLOT) begin
					pool_delta[pool_head] = pool_delta[pool_head] - 1;
					while (pool_head < NSLOT && pool_delta[pool_head] == 0)
						fire_timer(pool_head, 0);
				end
				push_result(K_DONE, 0, 0, 0);
			end
			OP_COMPLETE: begin
				if (pool_kind[id] == SK_LOW) begin
					unlink_entry(id);
					release_slot(id);
					push_result(K_LOW_HANDLER, id, 0, 0);
				end else begin
					push_result(K_DONE, id, 0, 0);
				end
			end
			OP_STATUS: push_result(K_STATUS, id, 0, pool_kind[id] != SK_FREE);
			default: ;
		endcase
		if (expected_results.size() > n_prior)
			expected_results[expected_results.size() - 1].last = 1;
	endtask

	// Send one request word, idling first at random, and predict its results.
	task automatic send_word(logic [2:0] op, logic hi, logic [15:0] dly, logic [3:0] id);
		int gap;
		if (!quiet_phase && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {3'b000, id, dly, hi};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_request(op, hi, dly, id);
	endtask

	task automatic drain_results();
		s_tvalid <= 0;
		while (expected_results.size() != 0 && !timed_out) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic random_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) send_word(OP_SET, 1'($urandom), ($urandom_range(0, 5) == 0) ? 16'd0 :
			(($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 8))),
			4'($urandom));
		else if (r < 65)
			send_word(OP_TICK, 1'($urandom), 16'($urandom), 4'($urandom));
		else if (r < 75)
			send_word(OP_CANCEL, 1'($urandom), 16'($urandom), 4'($urandom));
		else if (r < 85)
			send_word(OP_COMPLETE, 1'($urandom), 16'($urandom), 4'($urandom));
		else if (r < 95)
			send_word(OP_STATUS, 1'($urandom), 16'($urandom), 4'($urandom));
		else
			send_word(3'($urandom_range(5, 7)), 1'($urandom), 16'($urandom), 4'($urandom));
	endtask

	// Directed: every opcode, extremes, immediate timers, equal delays.
	task automatic test_directed();
		send_word(OP_STATUS, 1, 16'hFFFF, 4'd15);
		send_word(OP_SET, 1, 16'd0, 4'd0);
		send_word(OP_SET, 0, 16'd0, 4'd0);
		send_word(OP_COMPLETE, 0, 16'd0, 4'd1);
		send_word(OP_SET, 0, 16'd3, 4'd0);
		send_word(OP_SET, 1, 16'd3, 4'd0);
		send_word(OP_SET, 1, 16'd1, 4'd0);
		send_word(OP_SET, 0, 16'hFFFF, 4'd0);
		repeat (3) send_word(OP_TICK, 0, 16'd0, 4'd0);
		send_word(OP_CANCEL, 0, 16'd0, 4'd3);
		send_word(OP_CANCEL, 0, 16'd0, 4'd3);
		send_word(OP_COMPLETE, 0, 16'd0, 4'd2);
		send_word(OP_COMPLETE, 0, 16'd0, 4'd0);
		send_word(3'd5, 1, 16'hFFFF, 4'hF);
		send_word(3'd7, 0, 16'd0, 4'd0);
		for (int i = 0; i < 8; i++) send_word(OP_SET, i[0], 16'(i + 1), 4'd0);
		drain_results();
	endtask

	task automatic test_full_pool();
		for (int i = 0; i < 18; i++) send_word(OP_SET, 0, 16'd2, 4'd0);
		send_word(OP_TICK, 0, 16'd0, 4'd0);
		send_word(OP_TICK, 0, 16'd0, 4'd0);
		for (int i = 0; i < 16; i++) send_word(OP_COMPLETE, 0, 16'd0, 4'(i));
		drain_results();
	endtask

	// The receiver stalls long while requests keep coming.
	task automatic test_backpressure();
		hold_off = 1;
		for (int i = 0; i < 10; i++) random_word();
		hold_off = 0;
		drain_results();
	endtask

	task automatic test_random();
		for (int i = 0; i < 25; i++) random_word();
		quiet_phase = 1;
		for (int i = 0; i < 15; i++) random_word();
		drain_results();
	endtask

	// Receiver: random stall bursts, a long hold-off on request.
	initial begin
		int gap;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				m_tready <= 0;
				repeat (400) @(posedge clk);
				m_tready <= 1;
				do @(posedge clk); while (hold_off);
			end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
				gap = $urandom_range(1, 5);
				m_tready <= 0;
				repeat (gap) @(posedge clk);
			end else begin
				m_tready <= 1;
				@(posedge clk);
			end
		end
	end

	// Result checker.
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = m_tuser;
			got.slot = m_tdata[3:0];
			got.no_id = m_tdata[4];
			got.running = m_tdata[5];
			got.last = m_tlast;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", got);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"result mismatch: expected kind %0d slot %0d no_id %0b ",
							"run %0b last %0b, got kind %0d slot %0d no_id %0b run %0b last %0b"},
							want.kind, want.slot, want.no_id, want.running, want.last,
							got.kind, got.slot, got.no_id, got.running, got.last);
				end
			end
		end
	end

	// Watchdog on cycles with no handshake on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			timed_out = 1;
			$display("delta_list_timer_queue_core verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		for (int i = 0; i < NSLOT; i++) release_slot(i);
		pool_head = NIL;
		alloc_ptr = NSLOT - 1;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_full_pool();
		test_backpressure();
		test_random();
		if (mismatches == 0 && expected_results.size() == 0)
			$display("delta_list_timer_queue_core verification clean");
		else
			$display("delta_list_timer_queue_core verification failed");
		$finish;
	end

endmodule
